FILE: rtl/core/siaed_pkg.sv
// Package: constants, opcodes and status codes for the small integer ALU.
package siaed_pkg;
	localparam int INT_BITS_DEF = 30;
	localparam int OPW = 30;
	localparam int RESW = 60;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_XDIV = 4'd3,
		OP_DIV = 4'd4, OP_MOD = 4'd5, OP_LT = 4'd6, OP_EQ = 4'd7,
		OP_AND = 4'd8, OP_OR = 4'd9, OP_NEG = 4'd10
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_BIG = 2'd1, ST_INEXACT = 2'd2, ST_DIVZERO = 2'd3
	} status_t;
endpackage

FILE: rtl/core/small_int_alu_euclidean_divmod.sv
// Top level: pipelined small integer ALU with Euclidean divide and modulo.
//  channel | dir | tdata                                   | tuser
//  s_axis  | in  | cmd, operand_a, operand_b               | expand_ok
//  m_axis  | out | result_value, status                    | -
// One beat per cycle sustained while the output is not stalled.
// All stages share one enable: the pipe advances when the output register is
// free or being taken, so stalls hold every stage. The divider (one quotient
// bit per stage) sets the depth. Reset clears the valid bits only.
module small_int_alu_euclidean_divmod #(
	parameter int INT_BITS = siaed_pkg::INT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // cmd[3:0], operand_a[33:4], operand_b[63:34]
	input  logic        s_axis_tuser,  // expand_ok
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata   // result_value[59:0], status[61:60]
);
	localparam int W = siaed_pkg::OPW;
	localparam int D = INT_BITS + 1;
	localparam int P = 64;
	localparam int LAT = INT_BITS + 3;
	localparam logic signed [P-1:0] HALF = P'(1) <<< (INT_BITS - 1);

	logic en;
	logic [LAT:0] v_q;
	assign en = !v_q[LAT] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = v_q[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (en) v_q <= {v_q[LAT-1:0], s_axis_tvalid};
	end

	function automatic logic signed [P-1:0] wrapv(input logic signed [P-1:0] x);
		logic signed [P-1:0] t;
		t = x <<< (P - INT_BITS);
		return t >>> (P - INT_BITS);
	endfunction

	function automatic logic fits(input logic signed [P-1:0] x);
		return (x >= -HALF) && (x <= HALF - 1);
	endfunction

	// stage 1: operand reduction
	logic signed [P-1:0] a_s1, b_s1;
	logic [3:0] cmd_s1;
	logic x_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= s_axis_tdata[3:0];
			a_s1 <= wrapv({{(P-W){s_axis_tdata[33]}}, s_axis_tdata[33:4]});
			b_s1 <= wrapv({{(P-W){s_axis_tdata[63]}}, s_axis_tdata[63:34]});
			x_s1 <= s_axis_tuser;
		end
	end

	// stage 2: simple ops, product, magnitudes into divider
	typedef struct packed {
		logic [3:0] cmd;
		logic x;
		logic an;
		logic bn;
		logic bz;
		logic signed [P-1:0] simple;
		logic [1:0] st;
		logic [D-1:0] bmag;
	} tag_t;

	tag_t tin;
	logic [D-1:0] amag, bmag;
	assign amag = a_s1[P-1] ? D'(-a_s1) : D'(a_s1);
	assign bmag = b_s1[P-1] ? D'(-b_s1) : D'(b_s1);

	always_comb begin
		logic signed [P-1:0] t;
		tin = '0;
		tin.cmd = cmd_s1;
		tin.x = x_s1;
		tin.an = a_s1[P-1];
		tin.bn = b_s1[P-1];
		tin.bz = (b_s1 == '0);
		tin.bmag = bmag;
		tin.st = siaed_pkg::ST_OK;
		t = '0;
		case (cmd_s1)
			siaed_pkg::OP_ADD, siaed_pkg::OP_SUB: begin
				t = (cmd_s1 == siaed_pkg::OP_ADD) ? a_s1 + b_s1 : a_s1 - b_s1;
				if (!fits(t)) begin
					if (x_s1) tin.st = siaed_pkg::ST_BIG;
					else t = wrapv(t);
				end
			end
			siaed_pkg::OP_LT: t = P'(a_s1 < b_s1);
			siaed_pkg::OP_EQ: t = P'(a_s1 == b_s1);
			siaed_pkg::OP_AND: t = a_s1 & b_s1;
			siaed_pkg::OP_OR: t = a_s1 | b_s1;
			siaed_pkg::OP_NEG: begin
				t = -a_s1;
				if (!fits(t)) tin.st = siaed_pkg::ST_BIG;
			end
			default: t = '0;
		endcase
		tin.simple = t;
	end

	localparam int TW = $bits(tag_t);
	logic [D-1:0] q_d, r_d;
	logic [TW-1:0] tout;
	siaed_divpipe #(.W(D), .TW(TW)) u_div (
		.clk(clk), .en(en),
		.dividend(amag), .divisor(bmag), .tag_in(tin),
		.quot(q_d), .rem(r_d), .tag_out(tout)
	);

	// product travels alongside the divider
	logic signed [2*W-1:0] prod_c;
	assign prod_c = $signed(a_s1[W-1:0]) * $signed(b_s1[W-1:0]);

	logic signed [P-1:0] pd_q [0:D-1];
	always_ff @(posedge clk) begin
		if (en) begin
			pd_q[0] <= P'(prod_c);
			for (int i = 1; i < D; i++) pd_q[i] <= pd_q[i-1];
		end
	end

	// stage after divider: signed quotient/remainder fixups
	tag_t tg;
	assign tg = tag_t'(tout);
	logic signed [P-1:0] tq_s3, r_s3, bm_s3, prod_s3, simple_s3;
	logic [3:0] cmd_s3;
	logic x_s3, bz_s3, sdiff_s3, bn_s3, rnz_s3;
	logic [1:0] st_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			tq_s3 <= (tg.an ^ tg.bn) ? -P'(q_d) : P'(q_d);
			r_s3 <= tg.an ? -P'(r_d) : P'(r_d);
			rnz_s3 <= (r_d != '0);
			bm_s3 <= P'(tg.bmag);
			bn_s3 <= tg.bn;
			sdiff_s3 <= tg.an;
			prod_s3 <= pd_q[D-1];
			simple_s3 <= tg.simple;
			cmd_s3 <= tg.cmd;
			x_s3 <= tg.x;
			bz_s3 <= tg.bz;
			st_s3 <= tg.st;
		end
	end

	logic signed [P-1:0] res, eq, er;
	logic [1:0] st;
	always_comb begin
		eq = tq_s3;
		er = r_s3;
		if (sdiff_s3 && rnz_s3) begin
			er = bm_s3 + r_s3;
			eq = bn_s3 ? tq_s3 + 1 : tq_s3 - 1;
		end
		res = simple_s3;
		st = st_s3;
		case (cmd_s3)
			siaed_pkg::OP_MUL: begin
				res = prod_s3;
				st = fits(prod_s3) ? siaed_pkg::ST_OK : siaed_pkg::ST_BIG;
			end
			siaed_pkg::OP_XDIV, siaed_pkg::OP_DIV: begin
				res = (cmd_s3 == siaed_pkg::OP_XDIV) ? tq_s3 : eq;
				st = siaed_pkg::ST_OK;
				if (bz_s3) begin
					res = '0;
					st = siaed_pkg::ST_DIVZERO;
				end else if (cmd_s3 == siaed_pkg::OP_XDIV && x_s3 && rnz_s3) begin
					st = siaed_pkg::ST_INEXACT;
				end else if (!fits(res)) begin
					if (x_s3) st = siaed_pkg::ST_BIG;
					else res = wrapv(res);
				end
			end
			siaed_pkg::OP_MOD: begin
				res = bz_s3 ? '0 : er;
				st = bz_s3 ? siaed_pkg::ST_DIVZERO : siaed_pkg::ST_OK;
			end
			default: ;
		endcase
	end

	logic [63:0] out_q;
	always_ff @(posedge clk) begin
		if (en) out_q <= {2'b00, st, res[59:0]};
	end
	assign m_axis_tdata = out_q;
endmodule

FILE: rtl/core/siaed_divpipe.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
module siaed_divpipe #(
	parameter int W = 30,
	parameter int TW = 8
) (
	input  logic          clk,
	input  logic          en,
	input  logic [W-1:0]  dividend,
	input  logic [W-1:0]  divisor,
	input  logic [TW-1:0] tag_in,
	output logic [W-1:0]  quot,
	output logic [W-1:0]  rem,
	output logic [TW-1:0] tag_out
);
	logic [W-1:0]  n_s [1:W];
	logic [W-1:0]  d_s [1:W];
	logic [W-1:0]  r_s [1:W];
	logic [TW-1:0] t_s [1:W];

	for (genvar i = 0; i < W; i++) begin : g_stage
		logic [W-1:0]  n_in;
		logic [W-1:0]  d_in;
		logic [W-1:0]  r_in;
		logic [TW-1:0] t_in;
		logic [W:0] trial;
		logic [W:0] diff;
		if (i == 0) begin : g_first
			assign n_in = dividend;
			assign d_in = divisor;
			assign r_in = '0;
			assign t_in = tag_in;
		end else begin : g_next
			assign n_in = n_s[i];
			assign d_in = d_s[i];
			assign r_in = r_s[i];
			assign t_in = t_s[i];
		end
		assign trial = {r_in, n_in[W-1]};
		assign diff = trial - {1'b0, d_in};
		always_ff @(posedge clk) begin
			if (en) begin
				d_s[i+1] <= d_in;
				t_s[i+1] <= t_in;
				if (!diff[W]) begin
					r_s[i+1] <= diff[W-1:0];
					n_s[i+1] <= {n_in[W-2:0], 1'b1};
				end else begin
					r_s[i+1] <= trial[W-1:0];
					n_s[i+1] <= {n_in[W-2:0], 1'b0};
				end
			end
		end
	end

	assign quot = n_s[W];
	assign rem = r_s[W];
	assign tag_out = t_s[W];
endmodule
